>>> rtl/tlclru_pkg.sv
// Shared types, codes and defaults for the two-level cache LRU tracker.
`default_nettype none
package tlclru_pkg;

    localparam int MaxWaysDef  = 16;
    localparam int MaxRowsDef  = 256;
    localparam int AddrBitsDef = 16;

    localparam logic [5:0] BlockLog2Max = 6'd6;

    // Result status codes
    localparam logic [1:0] StHit   = 2'd0;
    localparam logic [1:0] StMiss  = 2'd1;
    localparam logic [1:0] StStore = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] RegTwoLevels = 3'd0;
    localparam logic [2:0] RegL1Block   = 3'd1;
    localparam logic [2:0] RegL1Ways    = 3'd2;
    localparam logic [2:0] RegL1Rows    = 3'd3;
    localparam logic [2:0] RegL2Block   = 3'd4;
    localparam logic [2:0] RegL2Ways    = 3'd5;
    localparam logic [2:0] RegL2Rows    = 3'd6;

    // Geometry of one cache level
    typedef struct packed {
        logic [2:0] blog;
        logic [2:0] wlog;
        logic [3:0] rlog;
    } t_geom;

endpackage
`default_nettype wire

>>> rtl/tlclru_level.sv
// One cache level: tag memory, per-row valid bits and the LRU lookup/update.
`default_nettype none
module tlclru_level #(
    parameter int MAX_WAYS  = tlclru_pkg::MaxWaysDef,
    parameter int MAX_ROWS  = tlclru_pkg::MaxRowsDef,
    parameter int ADDR_BITS = tlclru_pkg::AddrBitsDef
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [ADDR_BITS-1:0]   i_addr,
    input  wire tlclru_pkg::t_geom      i_geom,
    input  wire logic                   i_commit,
    output logic                        o_hit,
    output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] o_row
);
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int WLOG_MAX = $clog2(MAX_WAYS + 1) - 1;
    localparam int RLOG_MAX = $clog2(MAX_ROWS + 1) - 1;

    typedef logic [MAX_WAYS-1:0][ADDR_BITS:0] t_line;

    t_line                  mem [MAX_ROWS];
    logic [MAX_ROWS-1:0]    r_row_vld;
    t_line                  r_line;
    logic                   r_rv;
    logic [ROW_W-1:0]       r_row;
    logic [ADDR_BITS-1:0]   r_tag;
    logic [2:0]             r_wlog;

    logic [2:0]             b_s;
    logic [2:0]             w_s;
    logic [3:0]             r_s;
    logic [ADDR_BITS-1:0]   shifted;
    logic [ADDR_BITS-1:0]   rmask;
    logic [ROW_W-1:0]       set_idx;
    logic [ADDR_BITS-1:0]   tag_in;

    t_line              line;
    t_line              n_line;
    logic [WCNT_W-1:0]  ways;
    logic               found;
    logic [WAY_W-1:0]   idx;
    logic [WAY_W-1:0]   pos;

    always_comb begin
        b_s = (6'(i_geom.blog) > tlclru_pkg::BlockLog2Max) ? 3'(tlclru_pkg::BlockLog2Max)
                                                           : i_geom.blog;
        w_s = (i_geom.wlog > 3'(WLOG_MAX)) ? 3'(WLOG_MAX) : i_geom.wlog;
        r_s = (i_geom.rlog > 4'(RLOG_MAX)) ? 4'(RLOG_MAX) : i_geom.rlog;
        shifted = i_addr >> b_s;
        rmask   = ~({ADDR_BITS{1'b1}} << r_s);
        set_idx = ROW_W'(shifted & rmask);
        tag_in  = i_addr >> (5'(b_s) + 5'(r_s));
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_line <= mem[set_idx];
            r_rv   <= r_row_vld[set_idx];
            r_row  <= set_idx;
            r_tag  <= tag_in;
            r_wlog <= w_s;
        end
        if (i_commit) begin
            mem[r_row] <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_commit) begin
            r_row_vld[r_row] <= 1'b1;
        end
    end

    // Search from MRU; the first invalid slot ends the search as a miss.
    always_comb begin
        line  = r_rv ? r_line : '0;
        ways  = WCNT_W'(1) << r_wlog;
        found = 1'b0;
        idx   = '0;
        o_hit = 1'b0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!found && (WCNT_W'(i) < ways)
                && (!line[i][ADDR_BITS] || line[i][ADDR_BITS-1:0] == r_tag)) begin
                found = 1'b1;
                idx   = WAY_W'(i);
                o_hit = line[i][ADDR_BITS];
            end
        end
        pos = o_hit ? idx : WAY_W'(ways - WCNT_W'(1));
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i == 0) begin
                n_line[i] = {1'b1, r_tag};
            end else if (WAY_W'(i) <= pos && i < MAX_WAYS) begin
                n_line[i] = line[(i > 0) ? i - 1 : 0];
            end else begin
                n_line[i] = line[i];
            end
        end
        o_row = r_row;
    end

endmodule
`default_nettype wire

>>> rtl/two_level_cache_lru_tracker.sv
// Top level: config registers, access sequencer and result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  access   | start / busy           | i_op, i_address, i_pc
//  result   | o_valid (strobe)       | o_level, o_status, o_access_pc,
//           |                        | o_access_address, o_row, o_last
//  config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// The L1 row is read at the edge that accepts an access; the next cycle looks
// it up, writes it back and registers the L1 result. When L2 is consulted its
// row is read at that same edge and updated in the S_L2 state, which also
// registers the L2 result. Busy stays high until the last result is registered,
// so the next access can be accepted only once the state machine is idle again.
// Reset clears the state machine and the row valid bits; all ways then read
// invalid. Results cannot be stalled.
`default_nettype none
module two_level_cache_lru_tracker #(
    parameter int MAX_WAYS  = tlclru_pkg::MaxWaysDef,
    parameter int MAX_ROWS  = tlclru_pkg::MaxRowsDef,
    parameter int ADDR_BITS = tlclru_pkg::AddrBitsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_op,
    input  wire logic [15:0] i_address,
    input  wire logic [12:0] i_pc,
    output logic             o_valid,
    output logic             o_level,
    output logic [1:0]       o_status,
    output logic [12:0]      o_access_pc,
    output logic [15:0]      o_access_address,
    output logic [7:0]       o_row,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_L1, S_L2} t_state;

    t_state                 r_state;
    logic                   r_two;
    tlclru_pkg::t_geom      r_g1, r_g2;
    logic                   r_op;
    logic [ADDR_BITS-1:0]   r_addr;
    logic [12:0]            r_pc;

    logic                   accept;
    logic                   l1_hit, l2_hit;
    logic [ROW_W-1:0]       l1_row, l2_row;
    logic                   need_l2;
    logic                   l2_start;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign need_l2     = r_two && (r_op || !l1_hit);
    assign l2_start    = (r_state == S_L1) && need_l2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two <= 1'b0;
            r_g1  <= '0;
            r_g2  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tlclru_pkg::RegTwoLevels: r_two     <= i_cfg_data[0];
                tlclru_pkg::RegL1Block:   r_g1.blog <= i_cfg_data[2:0];
                tlclru_pkg::RegL1Ways:    r_g1.wlog <= i_cfg_data[2:0];
                tlclru_pkg::RegL1Rows:    r_g1.rlog <= i_cfg_data;
                tlclru_pkg::RegL2Block:   r_g2.blog <= i_cfg_data[2:0];
                tlclru_pkg::RegL2Ways:    r_g2.wlog <= i_cfg_data[2:0];
                tlclru_pkg::RegL2Rows:    r_g2.rlog <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_op;
            r_addr <= i_address[ADDR_BITS-1:0];
            r_pc   <= i_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_L1;
                end
                S_L1: begin
                    o_valid          <= 1'b1;
                    o_level          <= 1'b0;
                    o_status         <= r_op ? tlclru_pkg::StStore
                                      : (l1_hit ? tlclru_pkg::StHit : tlclru_pkg::StMiss);
                    o_access_pc      <= r_pc;
                    o_access_address <= 16'(r_addr);
                    o_row            <= 8'(l1_row);
                    o_last           <= !need_l2;
                    r_state          <= need_l2 ? S_L2 : S_IDLE;
                end
                S_L2: begin
                    o_valid  <= 1'b1;
                    o_level  <= 1'b1;
                    o_status <= r_op ? tlclru_pkg::StStore
                              : (l2_hit ? tlclru_pkg::StHit : tlclru_pkg::StMiss);
                    o_row    <= 8'(l2_row);
                    o_last   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tlclru_level #(.MAX_WAYS(MAX_WAYS), .MAX_ROWS(MAX_ROWS), .ADDR_BITS(ADDR_BITS)) u_l1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_addr   (i_address[ADDR_BITS-1:0]),
        .i_geom   (r_g1),
        .i_commit (r_state == S_L1),
        .o_hit    (l1_hit),
        .o_row    (l1_row)
    );

    tlclru_level #(.MAX_WAYS(MAX_WAYS), .MAX_ROWS(MAX_ROWS), .ADDR_BITS(ADDR_BITS)) u_l2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (l2_start),
        .i_addr   (r_addr),
        .i_geom   (r_g2),
        .i_commit (r_state == S_L2),
        .o_hit    (l2_hit),
        .o_row    (l2_row)
    );

endmodule
`default_nettype wire

>>> rtl/tlclru_checker.sv
// Port-level assertions for the tracker, bound to the top level.
`default_nettype none
module tlclru_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic       o_level,
    input wire logic [1:0] o_status,
    input wire logic       o_last
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted transaction not busy");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result after reset");

    a_l2_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid && o_level) else $error("missing L2 result");

    a_l2_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_level |-> o_last) else $error("L2 result not last");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");

endmodule

bind two_level_cache_lru_tracker tlclru_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_level  (o_level),
    .o_status (o_status),
    .o_last   (o_last)
);
`default_nettype wire
